// ----- rtl/vstw_pkg.sv -----
// shared types and constants for the variable slope triangle wave block
// no dependencies
package vstw_pkg;

    localparam int IDX_W   = 32;
    localparam int FREQ_W  = 24;
    localparam int RATE_W  = 16;
    localparam int FRAC_W  = 17;
    localparam int LVL_W   = 16;
    localparam int OUT_W   = 24;
    localparam int PER_W   = 24;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 17;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [CFG_A_W-1:0] REG_RATE = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_RISE = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_LOW  = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_HIGH = 2'd3;

    typedef struct packed {
        logic              v;
        logic [IDX_W-1:0]  idx;
        logic [FREQ_W-1:0] freq;
    } in_item_t;

    // period divider step
    typedef struct packed {
        logic              v;
        logic              bad;
        logic [IDX_W-1:0]  idx;
        logic [PER_W-1:0]  den;
        logic [PER_W-1:0]  num;
        logic [PER_W-1:0]  rem;
        logic [PER_W-1:0]  quo;
    } div1_t;

    // position modulo step
    typedef struct packed {
        logic              v;
        logic              bad;
        logic [PER_W-1:0]  period;
        logic [IDX_W-1:0]  num;
        logic [PER_W-1:0]  rem;
    } div2_t;

    typedef struct packed {
        logic              v;
        logic              bad;
        logic [PER_W-1:0]  period;
        logic [PER_W-1:0]  pos;
        logic [PER_W-1:0]  edge_pos;
    } edge_t;

    typedef struct packed {
        logic                    v;
        logic                    bad;
        logic                    neg;
        logic signed [LVL_W-1:0] base;
        logic [LVL_W-1:0]        span;
        logic [PER_W-1:0]        nn;
        logic [PER_W-1:0]        den;
    } sel_t;

    // slope divider step
    typedef struct packed {
        logic                    v;
        logic                    bad;
        logic                    neg;
        logic signed [LVL_W-1:0] base;
        logic [PER_W-1:0]        den;
        logic [PER_W-1:0]        num;
        logic [PER_W-1:0]        rem;
        logic [PER_W-1:0]        quo;
    } div3_t;

    typedef struct packed {
        logic             v;
        logic             bad;
        logic [OUT_W-1:0] level;
    } result_t;

endpackage

// ----- rtl/vstw_period.sv -----
// period division, position modulo and edge multiply, one bit per stage
// depends on vstw_pkg
module vstw_period import vstw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  in_item_t          in_item,
    input  logic [RATE_W-1:0] rate_hz,
    input  logic [FRAC_W-1:0] rise_fraction,
    output edge_t             edge_item
);

    div1_t s1 [0:PER_W];
    div2_t s2 [0:IDX_W];
    edge_t edge_reg;

    always_comb begin
        s1[0].v   = in_item.v;
        s1[0].bad = (in_item.freq == '0);
        s1[0].idx = in_item.idx;
        s1[0].den = in_item.freq;
        s1[0].num = {rate_hz, 8'h00};
        s1[0].rem = '0;
        s1[0].quo = '0;
    end

    for (genvar k = 0; k < PER_W; k++) begin : g_div1
        logic [PER_W:0] t;
        logic           ge;
        div1_t          nx;
        always_comb begin
            t      = {s1[k].rem, s1[k].num[PER_W-1]};
            ge     = (t >= {1'b0, s1[k].den});
            nx     = s1[k];
            nx.rem = ge ? PER_W'(t - {1'b0, s1[k].den}) : t[PER_W-1:0];
            nx.quo = {s1[k].quo[PER_W-2:0], ge};
            nx.num = {s1[k].num[PER_W-2:0], 1'b0};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s1[k+1].v <= 1'b0;
            end else if (en) begin
                s1[k+1] <= nx;
            end
        end
    end

    always_comb begin
        s2[0].v      = s1[PER_W].v;
        s2[0].bad    = s1[PER_W].bad | (s1[PER_W].quo == '0);
        s2[0].period = s1[PER_W].quo;
        s2[0].num    = s1[PER_W].idx;
        s2[0].rem    = '0;
    end

    for (genvar k = 0; k < IDX_W; k++) begin : g_div2
        logic [PER_W:0] t;
        logic           ge;
        div2_t          nx;
        always_comb begin
            t      = {s2[k].rem, s2[k].num[IDX_W-1]};
            ge     = (t >= {1'b0, s2[k].period});
            nx     = s2[k];
            nx.rem = ge ? PER_W'(t - {1'b0, s2[k].period}) : t[PER_W-1:0];
            nx.num = {s2[k].num[IDX_W-2:0], 1'b0};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s2[k+1].v <= 1'b0;
            end else if (en) begin
                s2[k+1] <= nx;
            end
        end
    end

    // rise share saturates at the whole period
    logic [FRAC_W-1:0]       frac_sat;
    logic [PER_W+FRAC_W-1:0] prod;
    edge_t                   edge_next;

    always_comb begin
        frac_sat           = (rise_fraction > FRAC_ONE) ? FRAC_ONE : rise_fraction;
        prod               = s2[IDX_W].period * frac_sat;
        edge_next.v        = s2[IDX_W].v;
        edge_next.bad      = s2[IDX_W].bad;
        edge_next.period   = s2[IDX_W].period;
        edge_next.pos      = s2[IDX_W].rem;
        edge_next.edge_pos = prod[PER_W+15:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg.v <= 1'b0;
        end else if (en) begin
            edge_reg <= edge_next;
        end
    end

    assign edge_item = edge_reg;

endmodule

// ----- rtl/vstw_slope.sv -----
// segment select, slope multiply, slope division and floor correction
// depends on vstw_pkg
module vstw_slope import vstw_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  edge_t                   edge_item,
    input  logic signed [LVL_W-1:0] level_low,
    input  logic signed [LVL_W-1:0] level_high,
    output result_t                 result
);

    sel_t  sel_reg, sel_next;
    div3_t s3 [0:PER_W];
    div3_t mul_next;
    logic  rising;
    logic signed [LVL_W:0] diff;
    logic [LVL_W:0]        absd;

    always_comb begin
        rising = (edge_item.pos < edge_item.edge_pos);
        diff   = rising ? ((LVL_W+1)'(level_high) - (LVL_W+1)'(level_low))
                        : ((LVL_W+1)'(level_low) - (LVL_W+1)'(level_high));
        absd   = diff[LVL_W] ? (LVL_W+1)'(-diff) : diff;
        sel_next.v    = edge_item.v;
        sel_next.bad  = edge_item.bad;
        sel_next.neg  = diff[LVL_W];
        sel_next.base = rising ? level_low : level_high;
        sel_next.span = absd[LVL_W-1:0];
        sel_next.nn   = rising ? edge_item.pos : PER_W'(edge_item.pos - edge_item.edge_pos);
        sel_next.den  = rising ? edge_item.edge_pos
                               : PER_W'(edge_item.period - edge_item.edge_pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg.v <= 1'b0;
        end else if (en) begin
            sel_reg <= sel_next;
        end
    end

    // quotient stays below the span times 256, so the top half already sits below the divisor
    logic [2*PER_W-1:0] mag;
    always_comb begin
        mag           = {sel_reg.span, 8'h00} * sel_reg.nn;
        mul_next.v    = sel_reg.v;
        mul_next.bad  = sel_reg.bad;
        mul_next.neg  = sel_reg.neg;
        mul_next.base = sel_reg.base;
        mul_next.den  = sel_reg.den;
        mul_next.rem  = mag[2*PER_W-1:PER_W];
        mul_next.num  = mag[PER_W-1:0];
        mul_next.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3[0].v <= 1'b0;
        end else if (en) begin
            s3[0] <= mul_next;
        end
    end

    for (genvar k = 0; k < PER_W; k++) begin : g_div3
        logic [PER_W:0] t;
        logic           ge;
        div3_t          nx;
        always_comb begin
            t      = {s3[k].rem, s3[k].num[PER_W-1]};
            ge     = (t >= {1'b0, s3[k].den});
            nx     = s3[k];
            nx.rem = ge ? PER_W'(t - {1'b0, s3[k].den}) : t[PER_W-1:0];
            nx.quo = {s3[k].quo[PER_W-2:0], ge};
            nx.num = {s3[k].num[PER_W-2:0], 1'b0};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s3[k+1].v <= 1'b0;
            end else if (en) begin
                s3[k+1] <= nx;
            end
        end
    end

    // floor of a negative quotient steps down when a remainder is left
    logic [PER_W:0] q_ext, adj;
    always_comb begin
        q_ext = {1'b0, s3[PER_W].quo};
        adj   = s3[PER_W].neg
              ? (PER_W+1)'(-q_ext - (PER_W+1)'(s3[PER_W].rem != '0)) : q_ext;
        result.v     = s3[PER_W].v;
        result.bad   = s3[PER_W].bad;
        result.level = s3[PER_W].bad ? '0
                     : OUT_W'({s3[PER_W].base, 8'h00} + adj[OUT_W-1:0]);
    end

endmodule

// ----- rtl/variable_slope_triangle_wave.sv -----
// variable slope triangle wave: one item per cycle sustained while results are taken;
// the depth is set by the three bit-serial dividers (24 + 32 + 24 stages) plus
// edge, select, multiply and output stages.
// the whole pipeline holds when a result waits and the output is not taken.
// synchronous active-low reset clears valid bits and loads register defaults.
module variable_slope_triangle_wave import vstw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,   // sample_index[31:0], freq_q8[55:32]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // level[23:0]
    output logic [0:0]         m_tuser    // bad_freq[0]
);

    logic [RATE_W-1:0]       rate_reg;
    logic [FRAC_W-1:0]       rise_reg;
    logic signed [LVL_W-1:0] low_reg, high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= 16'd44100;
            rise_reg <= 17'd32768;
            low_reg  <= -16'sd32768;
            high_reg <= 16'sd32767;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RATE: rate_reg <= cfg_wdata[RATE_W-1:0];
                REG_RISE: rise_reg <= cfg_wdata;
                REG_LOW:  low_reg  <= cfg_wdata[LVL_W-1:0];
                REG_HIGH: high_reg <= cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    logic     en;
    in_item_t in_item;
    edge_t    edge_item;
    result_t  result;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_level_reg;
    logic              m_bad_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign in_item.v    = s_tvalid;
    assign in_item.idx  = s_tdata[31:0];
    assign in_item.freq = s_tdata[55:32];

    vstw_period u_period (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_item       (in_item),
        .rate_hz       (rate_reg),
        .rise_fraction (rise_reg),
        .edge_item     (edge_item)
    );

    vstw_slope u_slope (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .edge_item  (edge_item),
        .level_low  (low_reg),
        .level_high (high_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= result.v;
            m_level_reg <= result.level;
            m_bad_reg   <= result.bad;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_level_reg;
    assign m_tuser[0] = m_bad_reg;

endmodule

// ----- test/variable_slope_triangle_wave_chk.sv -----
// checker for the variable slope triangle wave block: watches both streams,
// predicts each level from its own copy of the registers and compares
// depends on vstw_pkg
module variable_slope_triangle_wave_chk import vstw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [55:0]        s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [23:0]        m_tdata,
    input  logic [0:0]         m_tuser,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [23:0] level;
        logic        bad;
    } wave_level_t;

    logic [15:0]        rate_hz;
    logic [16:0]        rise_frac;
    logic signed [15:0] lvl_low;
    logic signed [15:0] lvl_high;
    wave_level_t        level_q[$];

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if (num < 0 && (num % den) != 0) q = q - 1;
        return q;
    endfunction

    function automatic wave_level_t wave_level(logic [31:0] idx, logic [23:0] freq);
        wave_level_t r;
        longint period, pos, edge_pos, frac, lo, hi, y;
        r.level = '0;
        r.bad   = 1'b1;
        if (freq == 0) return r;
        period = (longint'(rate_hz) * 256) / longint'(freq);
        if (period == 0) return r;
        pos  = longint'(idx) % period;
        frac = (rise_frac > FRAC_ONE) ? 65536 : longint'(rise_frac);
        edge_pos = (period * frac) >> 16;
        lo = longint'(lvl_low) * 256;
        hi = longint'(lvl_high) * 256;
        if (pos < edge_pos)
            y = lo + floor_quot((hi - lo) * pos, edge_pos);
        else
            y = hi + floor_quot((lo - hi) * (pos - edge_pos), period - edge_pos);
        r.level = y[23:0];
        r.bad   = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        wave_level_t w;
        if (!aresetn) begin
            errors     = 0;
            rate_hz   <= 16'd44100;
            rise_frac <= 17'd32768;
            lvl_low   <= -16'sd32768;
            lvl_high  <= 16'sd32767;
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_q.size() == 0) begin
                    report("unexpected item", m_tdata, '0);
                end else begin
                    w = level_q.pop_front();
                    if (m_tuser[0] !== w.bad) report("bad_freq", 24'(m_tuser), 24'(w.bad));
                    if (m_tdata !== w.level) report("level", m_tdata, w.level);
                end
            end
            if (s_tvalid && s_tready)
                level_q.push_back(wave_level(s_tdata[31:0], s_tdata[55:32]));
            if (cfg_we) begin
                case (cfg_index)
                    REG_RATE: rate_hz   <= cfg_wdata[15:0];
                    REG_RISE: rise_frac <= cfg_wdata;
                    REG_LOW:  lvl_low   <= cfg_wdata[15:0];
                    REG_HIGH: lvl_high  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        pending <= level_q.size();
    end

endmodule

// ----- test/variable_slope_triangle_wave_tb.sv -----
// top of the variable slope triangle wave regression: clock, reset, register
// phases, item stimulus and verdict; depends on vstw_pkg, the block and its checker
module variable_slope_triangle_wave_tb;
    import vstw_pkg::*;

    localparam int LATENCY = 84;
    localparam longint CYCLE_LIMIT = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0] cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [55:0]        s_tdata = '0;   // sample_index[31:0], freq_q8[55:32]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;        // level[23:0]
    logic [0:0]         m_tuser;        // bad_freq[0]
    int                 errors, pending;
    longint             cycles = 0;
    bit                 hold_off = 1'b0;

    variable_slope_triangle_wave dut (.*);
    variable_slope_triangle_wave_chk chk (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("variable_slope_triangle_wave regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, with one long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // valid stays high after an item so that the next one can follow at once
    task automatic send_item(logic [31:0] idx, logic [23:0] freq, bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {freq, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // mostly audio-like frequencies giving short periods, sometimes anything
    function automatic logic [23:0] pick_freq();
        case ($urandom_range(0, 9))
            0: return 24'($urandom_range(0, 24'hFFFFFF));
            1: return 24'($urandom_range(0, 4));
            2: return 24'($urandom_range(24'h100000, 24'hFFFFFF));
            default: return 24'($urandom_range(256, 24'h200000));
        endcase
    endfunction

    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'hFFFFFFFF - $urandom_range(0, 1000);
            default: return $urandom_range(0, 5000);
        endcase
    endfunction

    initial begin
        logic [16:0] rise_set [6] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd32768, 17'd49152};
        logic [15:0] rate_set [6] = '{16'd1, 16'd65535, 16'd48000, 16'd44100, 16'd8000, 16'd255};
        logic [15:0] low_set  [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFF00, 16'h8000, 16'h1234};
        logic [15:0] high_set [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'h8000, 16'hEDCB};
        int per_phase;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed items at reset settings
        send_item(32'd0, 24'd0, 1'b0);
        send_item(32'hFFFFFFFF, 24'd0, 1'b0);
        send_item(32'd0, 24'hFFFFFF, 1'b0);
        send_item(32'd5, 24'd1, 1'b0);
        send_item(32'hFFFFFFFF, 24'd1, 1'b0);
        send_item(32'd0, 24'd112896, 1'b1);
        send_item(32'd49, 24'd112896, 1'b1);
        send_item(32'd50, 24'd112896, 1'b1);
        send_item(32'd99, 24'd112896, 1'b1);
        send_item(32'hAAAAAAAA, 24'h555555, 1'b1);
        send_item(32'h55555555, 24'hAAAAAA, 1'b1);
        send_item(32'd12345, 24'd256, 1'b1);
        drain();

        // random phases over several register settings
        per_phase = 1850 / 6;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_RATE, rate_set[ph]);
            write_reg(REG_RISE, rise_set[ph]);
            write_reg(REG_LOW, low_set[ph]);
            write_reg(REG_HIGH, high_set[ph]);
            if (ph == 2) hold_off = 1'b1;
            // the hold-off phase sends back to back so that the pipeline fills
            for (int i = 0; i < per_phase; i++)
                send_item(pick_index(), pick_freq(), (ph != 2) && ($urandom_range(0, 3) != 0));
            drain();
        end

        if (errors == 0) begin
            $display("variable_slope_triangle_wave regression: pass");
        end else begin
            $display("variable_slope_triangle_wave regression: fail");
        end
        $finish;
    end

endmodule
